// ----- rtl/core/ufr_pkg.sv -----
// Package with shared types and constants of the UART frame receiver.
`timescale 1ns / 1ps

package ufr_pkg;

    localparam int DATA_WIDTH_DEF  = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TICKS_PER_BIT  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PARITY_ENABLE  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PARITY_ODD     = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STOP_BIT_COUNT = 2'd3;

    localparam logic [15:0] TICKS_PER_BIT_RST  = 16'd16;
    localparam logic        PARITY_ENABLE_RST  = 1'b1;
    localparam logic        PARITY_ODD_RST     = 1'b0;
    localparam logic [1:0]  STOP_BIT_COUNT_RST = 2'd1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_PARITY_ERR = 2'd1;
    localparam logic [1:0] STATUS_STOP_ERR   = 2'd2;

    typedef enum logic [2:0] {
        PH_WAIT_IDLE = 3'd0,
        PH_WAIT_FALL = 3'd1,
        PH_HALF      = 3'd2,
        PH_DATA      = 3'd3,
        PH_PARITY    = 3'd4,
        PH_STOP      = 3'd5
    } phase_t;

    typedef struct packed {
        logic [15:0] ticks_per_bit;
        logic        parity_enable;
        logic        parity_odd;
        logic [1:0]  stop_bit_count;
    } cfg_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] rx_byte;
        logic [1:0] frame_status;
    } result_t;

endpackage

// ----- rtl/core/uart_frame_receiver.sv -----
// Top level of the UART frame receiver with configuration registers and input register.
`timescale 1ns / 1ps

// Usage: each input word is one clock tick of the sampled serial line on rx_level,
// taken when in_valid is high and in_stall is low. The block accepts one word
// every cycle while in_stall is low. Each accepted word is held in the input
// register and is then stepped through the frame state machine; a frame result
// is loaded into the output register (out_valid, rx_byte, frame_status) when the
// word holding the last stop bit (or the failing parity or stop bit) is stepped.
// A result word stays in the output register until out_stall is low. While it
// waits, line samples keep flowing; in_stall rises only when a sample would
// finish another frame while the output register is still held.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 is ticks_per_bit, 1 parity_enable, 2 parity_odd, 3 stop_bit_count.
// Write it only while the line is idle and no result is pending.
// Reset returns the registers to 16 ticks per bit, even parity enabled and one
// stop bit, empties both registers, and the receiver waits for the idle high level.
module uart_frame_receiver #(
    parameter int DATA_WIDTH  = ufr_pkg::DATA_WIDTH_DEF,
    parameter int COUNT_WIDTH = ufr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                rx_level,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          rx_byte,
    output logic [1:0]                          frame_status,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ufr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [ufr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import ufr_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    logic    level_reg;
    logic    advance;
    logic    out_free;
    result_t result;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!result.emit || out_free);
    assign in_stall  = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_bit  <= TICKS_PER_BIT_RST;
            cfg_reg.parity_enable  <= PARITY_ENABLE_RST;
            cfg_reg.parity_odd     <= PARITY_ODD_RST;
            cfg_reg.stop_bit_count <= STOP_BIT_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TICKS_PER_BIT:  cfg_reg.ticks_per_bit  <= cfg_data;
                CFG_PARITY_ENABLE:  cfg_reg.parity_enable  <= cfg_data[0];
                CFG_PARITY_ODD:     cfg_reg.parity_odd     <= cfg_data[0];
                CFG_STOP_BIT_COUNT: cfg_reg.stop_bit_count <= cfg_data[1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            level_reg <= rx_level;
        end
    end

    ufr_frame_fsm #(
        .DATA_WIDTH  (DATA_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .rx_level (level_reg),
        .cfg      (cfg_reg),
        .result   (result)
    );

    ufr_out_buf u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && result.emit),
        .result       (result),
        .out_stall    (out_stall),
        .out_free     (out_free),
        .out_valid    (out_valid),
        .rx_byte      (rx_byte),
        .frame_status (frame_status)
    );

endmodule

// ----- rtl/core/ufr_frame_fsm.sv -----
// Frame state machine: bit timing, data assembly, parity and stop checks.
`timescale 1ns / 1ps

module ufr_frame_fsm #(
    parameter int DATA_WIDTH  = ufr_pkg::DATA_WIDTH_DEF,
    parameter int COUNT_WIDTH = ufr_pkg::COUNT_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             rx_level,
    input  ufr_pkg::cfg_t    cfg,
    output ufr_pkg::result_t result
);
    import ufr_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    phase_t                  phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]  tick_reg, tick_next;
    logic [3:0]              bit_index_reg, bit_index_next;
    logic [DATA_WIDTH-1:0]   shift_reg, shift_next;
    logic [1:0]              stop_index_reg, stop_index_next;

    logic [15:0]             limit;
    logic [COUNT_WIDTH-1:0]  limit_clip;
    logic [COUNT_WIDTH-1:0]  tick_inc;
    logic                    reached;
    logic                    parity_bit;
    logic [1:0]              stops;
    logic [3:0]              bit_index_inc;
    logic [1:0]              stop_index_inc;

    assign limit      = (phase_reg == PH_HALF) ? (cfg.ticks_per_bit >> 1) : cfg.ticks_per_bit;
    assign limit_clip = (32'(limit) > 32'(CNT_MAX)) ? CNT_MAX : COUNT_WIDTH'(limit);
    assign tick_inc   = (tick_reg == CNT_MAX) ? tick_reg : tick_reg + 1'b1;
    assign reached    = tick_inc >= limit_clip;
    assign parity_bit = (^shift_reg) ^ cfg.parity_odd;
    assign stops      = (cfg.stop_bit_count == 2'd0) ? 2'd1 :
                        (cfg.stop_bit_count == 2'd3) ? 2'd2 : cfg.stop_bit_count;
    assign bit_index_inc  = bit_index_reg + 4'd1;
    assign stop_index_inc = stop_index_reg + 2'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        stop_index_next = stop_index_reg;
        unique case (phase_reg)
            PH_WAIT_IDLE:
            begin
                if (rx_level)
                begin
                    phase_next = PH_WAIT_FALL;
                end
            end
            PH_WAIT_FALL:
            begin
                if (!rx_level)
                begin
                    phase_next = PH_HALF;
                    tick_next  = '0;
                end
            end
            PH_HALF:
            begin
                tick_next = tick_inc;
                if (reached)
                begin
                    tick_next = '0;
                    if (rx_level)
                    begin
                        phase_next = PH_WAIT_IDLE;
                    end
                    else
                    begin
                        phase_next     = PH_DATA;
                        bit_index_next = '0;
                        shift_next     = '0;
                    end
                end
            end
            PH_DATA:
            begin
                tick_next = tick_inc;
                if (reached)
                begin
                    tick_next = '0;
                    for (int i = 0; i < DATA_WIDTH; i++)
                    begin
                        if (bit_index_reg == 4'(i))
                        begin
                            shift_next[i] = shift_reg[i] | rx_level;
                        end
                    end
                    bit_index_next = bit_index_inc;
                    if (bit_index_inc >= 4'(DATA_WIDTH))
                    begin
                        stop_index_next = '0;
                        phase_next      = cfg.parity_enable ? PH_PARITY : PH_STOP;
                    end
                end
            end
            PH_PARITY:
            begin
                tick_next = tick_inc;
                if (reached)
                begin
                    tick_next = '0;
                    if (rx_level != parity_bit)
                    begin
                        phase_next = PH_WAIT_IDLE;
                    end
                    else
                    begin
                        stop_index_next = '0;
                        phase_next      = PH_STOP;
                    end
                end
            end
            PH_STOP:
            begin
                tick_next = tick_inc;
                if (reached)
                begin
                    tick_next = '0;
                    if (!rx_level)
                    begin
                        phase_next = PH_WAIT_IDLE;
                    end
                    else
                    begin
                        stop_index_next = stop_index_inc;
                        if (stop_index_inc >= stops)
                        begin
                            phase_next = PH_WAIT_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_WAIT_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result.emit         = 1'b0;
        result.rx_byte      = 8'(shift_reg);
        result.frame_status = STATUS_OK;
        unique case (phase_reg)
            PH_PARITY:
            begin
                if (reached && (rx_level != parity_bit))
                begin
                    result.emit         = 1'b1;
                    result.frame_status = STATUS_PARITY_ERR;
                end
            end
            PH_STOP:
            begin
                if (reached)
                begin
                    if (!rx_level)
                    begin
                        result.emit         = 1'b1;
                        result.frame_status = STATUS_STOP_ERR;
                    end
                    else if (stop_index_inc >= stops)
                    begin
                        result.emit = 1'b1;
                    end
                end
            end
            default:
            begin
                result.emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT_IDLE;
            tick_reg       <= '0;
            bit_index_reg  <= '0;
            shift_reg      <= '0;
            stop_index_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            bit_index_reg  <= bit_index_next;
            shift_reg      <= shift_next;
            stop_index_reg <= stop_index_next;
        end
    end

endmodule

// ----- rtl/core/ufr_out_buf.sv -----
// Output register that holds a finished frame until the receiver takes it.
`timescale 1ns / 1ps

module ufr_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  ufr_pkg::result_t result,
    input  logic             out_stall,
    output logic             out_free,
    output logic             out_valid,
    output logic [7:0]       rx_byte,
    output logic [1:0]       frame_status
);
    import ufr_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [1:0] status_reg;

    assign out_free     = !valid_reg || !out_stall;
    assign out_valid    = valid_reg;
    assign rx_byte      = byte_reg;
    assign frame_status = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && out_free)
        begin
            byte_reg   <= result.rx_byte;
            status_reg <= result.frame_status;
        end
    end

endmodule
